// ----- rtl/core/trn_pkg.sv -----
`timescale 1ns / 1ps

package trn_pkg;

    localparam int MAX_WORDS  = 64;
    localparam int IDX_W      = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS + 2);
    localparam int LEN_W      = 7;
    localparam int LABEL_W    = 8;
    localparam int HEAD_W     = 7;
    localparam int WORD_W     = 6;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [LABEL_W-1:0] t_label;

    typedef enum logic [1:0] {
        ACT_SHIFT = 2'd0,
        ACT_SWAP  = 2'd1,
        ACT_LEFT  = 2'd2,
        ACT_RIGHT = 2'd3
    } t_act;

    typedef struct packed {
        t_cnt   ss;
        t_cnt   bs;
        t_act   kind;
        t_idx   sec;
        t_idx   top;
        t_idx   btop;
    } t_exec_in;

    typedef struct packed {
        logic   forbid;
        logic   st_we;
        t_idx   st_addr;
        t_idx   st_wdata;
        logic   bf_we;
        t_idx   bf_addr;
        t_idx   bf_wdata;
        logic   arc_we;
        t_idx   arc_dep;
        t_idx   arc_head;
        t_cnt   ss_nxt;
        t_cnt   bs_nxt;
    } t_exec_out;

endpackage

// ----- rtl/core/trn_ram.sv -----
`timescale 1ns / 1ps

module trn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/trn_arc_store.sv -----
`timescale 1ns / 1ps

module trn_arc_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_we,
    input  trn_pkg::t_idx                 i_wdep,
    input  trn_pkg::t_idx                 i_whead,
    input  trn_pkg::t_label               i_wlabel,
    input  logic                          i_re,
    input  trn_pkg::t_idx                 i_raddr,
    output logic signed [trn_pkg::HEAD_W-1:0] o_head,
    output trn_pkg::t_label               o_label
);

    localparam int ARC_W = trn_pkg::IDX_W + trn_pkg::LABEL_W;

    logic [trn_pkg::MAX_WORDS-1:0] r_valid;
    logic                          r_rd_valid;
    logic [ARC_W-1:0]              w_rdata;
    trn_pkg::t_idx                 w_head;

    trn_ram #(
        .WIDTH (ARC_W),
        .DEPTH (trn_pkg::MAX_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_wdep),
        .i_wdata ({i_whead, i_wlabel}),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    // drop all arcs at once; a word without valid bit reads as no head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wdep] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_re) begin
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign w_head  = w_rdata[ARC_W-1:trn_pkg::LABEL_W];
    assign o_head  = r_rd_valid ? trn_pkg::HEAD_W'({1'b0, w_head}) : '1;
    assign o_label = r_rd_valid ? w_rdata[trn_pkg::LABEL_W-1:0] : '0;

endmodule

// ----- rtl/core/trn_exec.sv -----
`timescale 1ns / 1ps

module trn_exec (
    input  trn_pkg::t_exec_in  i_req,
    output trn_pkg::t_exec_out o_res
);

    logic          w_shift;
    logic          w_forbid;
    trn_pkg::t_cnt w_ss_m1;
    trn_pkg::t_cnt w_ss_m3;
    trn_pkg::t_cnt w_bs_m1;

    assign w_shift = (i_req.kind == trn_pkg::ACT_SHIFT);
    assign w_ss_m1 = i_req.ss - trn_pkg::t_cnt'(1);
    assign w_ss_m3 = i_req.ss - trn_pkg::t_cnt'(3);
    assign w_bs_m1 = i_req.bs - trn_pkg::t_cnt'(1);

    // legality rules of the transition system
    always_comb begin
        w_forbid = 1'b0;
        if (i_req.kind == trn_pkg::ACT_SWAP &&
            (i_req.ss < trn_pkg::t_cnt'(3) || i_req.sec > i_req.top)) begin
            w_forbid = 1'b1;
        end
        if (w_shift && i_req.bs == trn_pkg::t_cnt'(1)) begin
            w_forbid = 1'b1;
        end
        if (!w_shift && i_req.ss < trn_pkg::t_cnt'(3)) begin
            w_forbid = 1'b1;
        end
        if (w_shift && i_req.bs == trn_pkg::t_cnt'(2) && i_req.ss > trn_pkg::t_cnt'(2)) begin
            w_forbid = 1'b1;
        end
        if (i_req.kind == trn_pkg::ACT_RIGHT && i_req.bs == trn_pkg::t_cnt'(1) &&
            i_req.ss == trn_pkg::t_cnt'(3)) begin
            w_forbid = 1'b1;
        end
    end

    always_comb begin
        o_res        = '0;
        o_res.forbid = w_forbid;
        o_res.ss_nxt = i_req.ss;
        o_res.bs_nxt = i_req.bs;
        if (!w_forbid) begin
            unique case (i_req.kind)
                trn_pkg::ACT_SHIFT: begin
                    if (i_req.ss <= trn_pkg::t_cnt'(trn_pkg::MAX_WORDS)) begin
                        o_res.st_we    = 1'b1;
                        o_res.st_addr  = w_ss_m1[trn_pkg::IDX_W-1:0];
                        o_res.st_wdata = i_req.btop;
                        o_res.ss_nxt   = i_req.ss + trn_pkg::t_cnt'(1);
                        o_res.bs_nxt   = w_bs_m1;
                    end
                end
                trn_pkg::ACT_SWAP: begin
                    if (i_req.bs <= trn_pkg::t_cnt'(trn_pkg::MAX_WORDS)) begin
                        o_res.bf_we    = 1'b1;
                        o_res.bf_addr  = w_bs_m1[trn_pkg::IDX_W-1:0];
                        o_res.bf_wdata = i_req.sec;
                        o_res.bs_nxt   = i_req.bs + trn_pkg::t_cnt'(1);
                        o_res.st_we    = 1'b1;
                        o_res.st_addr  = w_ss_m3[trn_pkg::IDX_W-1:0];
                        o_res.st_wdata = i_req.top;
                        o_res.ss_nxt   = w_ss_m1;
                    end
                end
                trn_pkg::ACT_LEFT: begin
                    o_res.st_we    = 1'b1;
                    o_res.st_addr  = w_ss_m3[trn_pkg::IDX_W-1:0];
                    o_res.st_wdata = i_req.top;
                    o_res.ss_nxt   = w_ss_m1;
                    o_res.arc_we   = 1'b1;
                    o_res.arc_dep  = i_req.sec;
                    o_res.arc_head = i_req.top;
                end
                trn_pkg::ACT_RIGHT: begin
                    o_res.st_we    = 1'b1;
                    o_res.st_addr  = w_ss_m3[trn_pkg::IDX_W-1:0];
                    o_res.st_wdata = i_req.sec;
                    o_res.ss_nxt   = w_ss_m1;
                    o_res.arc_we   = 1'b1;
                    o_res.arc_dep  = i_req.top;
                    o_res.arc_head = i_req.sec;
                end
                default: begin
                    o_res.forbid = w_forbid;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/transition_parser_state_machine.sv -----
`timescale 1ns / 1ps

// Dependency-parse transition executor (arc-standard with swap).
// Slave channel: one request per transition. tdata = sentence length [6:0],
// relation_label [14:7]; tuser = first_of_sentence [0], action_kind [2:1];
// tlast = last_action. A request with first_of_sentence reloads the buffer
// with words 0..length-1 (word 0 on top) and drops all arcs first.
// Master channel: tdata = word_index [5:0], head_index [12:6] (signed, -1
// for no head), dep_label [20:13]; tuser = status (1 = forbidden, ignored);
// tlast = end_of_run. A non-final request gives one result; the final one
// gives one result per word of the sentence, word 0 first.
// Sequence: accept (reads of the stack and buffer memories issued), execute
// against those memories (write-back in the execute state), then the result
// register loads. A final request then reads the arc memory and loads the
// result register once for each word of the sentence, in turn. One request
// is in flight at a time.
// A stalled receiver holds the output register and the sequencer waits;
// a new request is taken while the last result still waits to be read.
// Reset (synchronous, active low) empties stack and buffer and drops arcs.
module transition_parser_state_machine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [trn_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,   // length, relation_label
    input  logic [trn_pkg::IN_USER_W-1:0]  i_s_axis_tuser,   // first_of_sentence, action_kind
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [trn_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,   // word_index, head_index, dep_label
    output logic [0:0]                     o_m_axis_tuser,   // status
    output logic                           o_m_axis_tlast
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ONE  = 5'b00100,
        S_RD   = 5'b01000,
        S_LD   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // control state
    trn_pkg::t_cnt   r_ss;
    trn_pkg::t_cnt   r_bs;
    trn_pkg::t_cnt   r_wt;
    trn_pkg::t_cnt   r_blow;
    trn_pkg::t_idx   r_idx;

    // request held for execute
    trn_pkg::t_act   r_kind;
    trn_pkg::t_label r_label;
    logic            r_last;
    logic            r_status;
    trn_pkg::t_idx   r_baddr;

    // result register
    logic                                 r_o_valid;
    logic                                 r_o_status;
    logic [trn_pkg::WORD_W-1:0]           r_o_word;
    logic signed [trn_pkg::HEAD_W-1:0]    r_o_head;
    trn_pkg::t_label                      r_o_label;
    logic                                 r_o_last;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_first;
    logic [trn_pkg::LEN_W-1:0]     w_len;
    trn_pkg::t_cnt                 w_len_sat;
    trn_pkg::t_cnt                 w_ss;
    trn_pkg::t_cnt                 w_bs;
    trn_pkg::t_cnt                 w_sec_addr;
    trn_pkg::t_cnt                 w_top_addr;
    trn_pkg::t_cnt                 w_btop_addr;
    trn_pkg::t_cnt                 w_orig;
    trn_pkg::t_idx                 w_sec;
    trn_pkg::t_idx                 w_top;
    trn_pkg::t_idx                 w_bmem;
    trn_pkg::t_idx                 w_btop;
    trn_pkg::t_exec_in             w_req;
    trn_pkg::t_exec_out            w_res;
    logic                          w_exec;
    logic signed [trn_pkg::HEAD_W-1:0] w_arc_head;
    trn_pkg::t_label               w_arc_label;
    logic                          w_run_end;
    trn_pkg::t_cnt                 w_live;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_o_valid || i_m_axis_tready;
    assign w_first    = i_s_axis_tuser[0];
    assign w_len      = i_s_axis_tdata[trn_pkg::LEN_W-1:0];
    assign w_exec     = (r_state == S_EXEC);

    // clamp the sentence length to 1..MAX_WORDS
    always_comb begin
        if (w_len == '0) begin
            w_len_sat = trn_pkg::t_cnt'(1);
        end else if (w_len > trn_pkg::MAX_WORDS) begin
            w_len_sat = trn_pkg::t_cnt'(trn_pkg::MAX_WORDS);
        end else begin
            w_len_sat = trn_pkg::t_cnt'(w_len);
        end
    end

    // counts as seen by this request, after an optional reload
    assign w_ss        = w_first ? trn_pkg::t_cnt'(1) : r_ss;
    assign w_bs        = w_first ? w_len_sat + trn_pkg::t_cnt'(1) : r_bs;
    assign w_sec_addr  = w_ss - trn_pkg::t_cnt'(3);
    assign w_top_addr  = w_ss - trn_pkg::t_cnt'(2);
    assign w_btop_addr = w_bs - trn_pkg::t_cnt'(2);

    // stack: two copies written alike give the second read port
    trn_ram #(
        .WIDTH (trn_pkg::IDX_W),
        .DEPTH (trn_pkg::MAX_WORDS)
    ) u_stack_sec (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_res.st_we),
        .i_waddr (w_res.st_addr),
        .i_wdata (w_res.st_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_sec_addr[trn_pkg::IDX_W-1:0]),
        .o_rdata (w_sec)
    );

    trn_ram #(
        .WIDTH (trn_pkg::IDX_W),
        .DEPTH (trn_pkg::MAX_WORDS)
    ) u_stack_top (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_res.st_we),
        .i_waddr (w_res.st_addr),
        .i_wdata (w_res.st_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_top_addr[trn_pkg::IDX_W-1:0]),
        .o_rdata (w_top)
    );

    trn_ram #(
        .WIDTH (trn_pkg::IDX_W),
        .DEPTH (trn_pkg::MAX_WORDS)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_res.bf_we),
        .i_waddr (w_res.bf_addr),
        .i_wdata (w_res.bf_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_btop_addr[trn_pkg::IDX_W-1:0]),
        .o_rdata (w_bmem)
    );

    // Buffer slots below the lowest swap write since reload still hold
    // their reload value, word_total-1-slot; compute it instead of filling.
    assign w_orig = r_wt - trn_pkg::t_cnt'(1) - trn_pkg::t_cnt'(r_baddr);
    assign w_btop = (trn_pkg::t_cnt'(r_baddr) >= r_blow) ? w_bmem
                                                         : w_orig[trn_pkg::IDX_W-1:0];

    always_comb begin
        w_req       = '0;
        w_req.ss    = r_ss;
        w_req.bs    = r_bs;
        w_req.kind  = r_kind;
        w_req.sec   = w_sec;
        w_req.top   = w_top;
        w_req.btop  = w_btop;
    end

    trn_exec u_exec (
        .i_req (w_req),
        .o_res (w_res)
    );

    trn_arc_store u_arcs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_in_acc && w_first),
        .i_we     (w_exec && w_res.arc_we),
        .i_wdep   (w_res.arc_dep),
        .i_whead  (w_res.arc_head),
        .i_wlabel (r_label),
        .i_re     (r_state == S_RD),
        .i_raddr  (r_idx),
        .o_head   (w_arc_head),
        .o_label  (w_arc_label)
    );

    assign w_run_end = (trn_pkg::t_cnt'(r_idx) + trn_pkg::t_cnt'(1) == r_wt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_last || r_wt == '0) begin
                    n_state = S_ONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (w_out_free) begin
                    n_state = w_run_end ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sentence counts: reload on accepting a first_of_sentence request, update on execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss   <= trn_pkg::t_cnt'(1);
            r_bs   <= trn_pkg::t_cnt'(1);
            r_wt   <= '0;
            r_blow <= trn_pkg::t_cnt'(trn_pkg::MAX_WORDS);
        end else if (w_in_acc && w_first) begin
            r_ss   <= trn_pkg::t_cnt'(1);
            r_bs   <= w_len_sat + trn_pkg::t_cnt'(1);
            r_wt   <= w_len_sat;
            r_blow <= trn_pkg::t_cnt'(trn_pkg::MAX_WORDS);
        end else if (w_exec) begin
            r_ss <= w_res.ss_nxt;
            r_bs <= w_res.bs_nxt;
            if (w_res.bf_we && trn_pkg::t_cnt'(w_res.bf_addr) < r_blow) begin
                r_blow <= trn_pkg::t_cnt'(w_res.bf_addr);
            end
        end
    end

    // hold the request fields for the execute cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind  <= trn_pkg::t_act'(i_s_axis_tuser[2:1]);
            r_label <= i_s_axis_tdata[trn_pkg::LEN_W +: trn_pkg::LABEL_W];
            r_last  <= i_s_axis_tlast;
            r_baddr <= w_btop_addr[trn_pkg::IDX_W-1:0];
        end
        if (w_exec) begin
            r_status <= w_res.forbid;
        end
    end

    // word counter of the final run
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_idx <= '0;
        end else if (r_state == S_LD && w_out_free) begin
            r_idx <= r_idx + trn_pkg::t_idx'(1);
        end
    end

    // result register: load when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free && (r_state == S_ONE || r_state == S_LD)) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_state == S_ONE) begin
            r_o_status <= r_status;
            r_o_word   <= '0;
            r_o_head   <= '0;
            r_o_label  <= '0;
            r_o_last   <= 1'b1;
        end else if (w_out_free && r_state == S_LD) begin
            r_o_status <= r_status;
            r_o_word   <= trn_pkg::WORD_W'(r_idx);
            r_o_head   <= w_arc_head;
            r_o_label  <= w_arc_label;
            r_o_last   <= w_run_end;
        end
    end

    assign o_s_axis_tready   = (r_state == S_IDLE);
    assign o_m_axis_tvalid   = r_o_valid;
    assign o_m_axis_tdata    = {3'b000, r_o_label, r_o_head, r_o_word};
    assign o_m_axis_tuser[0] = r_o_status;
    assign o_m_axis_tlast    = r_o_last;

    assign w_live = (r_ss - trn_pkg::t_cnt'(1)) + (r_bs - trn_pkg::t_cnt'(1));

    a_req_goes_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ss >= trn_pkg::t_cnt'(1)) && (r_ss <= trn_pkg::t_cnt'(trn_pkg::MAX_WORDS + 1)))
        else $error("stack count out of range");

    a_words_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_live <= r_wt))
        else $error("stack and buffer hold more words than the sentence");

    a_run_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD) |-> (trn_pkg::t_cnt'(r_idx) < r_wt))
        else $error("run index beyond word count");

    a_run_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && r_last && (r_wt != '0) |=> (r_state == S_RD) && (r_idx == '0))
        else $error("final run did not start at word zero");

endmodule
